/* sv/tsct_pkg.sv */
package tsct_pkg;

	localparam int SERIES_TERMS  = 6;
	localparam int FRACTION_BITS = 16;
	localparam int GUARD_BITS    = 8;
	localparam int WORK_BITS     = FRACTION_BITS + GUARD_BITS;
	localparam int ANGLE_FRAC    = 13;
	localparam int NUM_TERMS     = 2 * SERIES_TERMS - 1;
	localparam int ANGLE_W       = 16;
	// Term magnitudes stay below 11.0 for any angle in range.
	localparam int TERM_W        = WORK_BITS + 4;
	localparam int SUM_W         = WORK_BITS + 8;
	localparam int PROD_W        = TERM_W + ANGLE_W;
	localparam int U_W           = 32;
	localparam int RECIP_W       = 33;
	localparam int STEP_W        = 4;
	localparam int TRIG_W        = 20;
	localparam int TAN_W         = 32;
	localparam int NUM_W         = TRIG_W + FRACTION_BITS;
	localparam int REM_W         = TRIG_W + 1;

	typedef struct packed {
		logic                     vld;
		logic                     neg;
		logic [ANGLE_W-1:0]       mag;
		logic [TERM_W-1:0]        term;
		logic signed [SUM_W-1:0]  ssum;
		logic signed [SUM_W-1:0]  csum;
	} tsct_term_t;

	typedef struct packed {
		logic                     vld;
		logic signed [TRIG_W-1:0] sv;
		logic signed [TRIG_W-1:0] cv;
		logic                     tneg;
		logic                     dz;
		logic [TRIG_W-1:0]        cm;
		logic [REM_W-1:0]         rem;
		logic [NUM_W-1:0]         rq;
	} tsct_div_t;

	// floor(2^32 / n) for the small term divisors
	function automatic logic [RECIP_W-1:0] recip(input logic [STEP_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1:    r = 33'd4294967296;
			4'd2:    r = 33'd2147483648;
			4'd3:    r = 33'd1431655765;
			4'd4:    r = 33'd1073741824;
			4'd5:    r = 33'd858993459;
			4'd6:    r = 33'd715827882;
			4'd7:    r = 33'd613566756;
			4'd8:    r = 33'd536870912;
			4'd9:    r = 33'd477218588;
			4'd10:   r = 33'd429496729;
			4'd11:   r = 33'd390451572;
			4'd12:   r = 33'd357913941;
			4'd13:   r = 33'd330382099;
			4'd14:   r = 33'd306783378;
			4'd15:   r = 33'd286331153;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* sv/tsct_if.sv */
interface tsct_in_if;
	import tsct_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] angle;
	modport source (output valid, angle, input ready);
	modport sink   (input valid, angle, output ready);
endinterface

interface tsct_out_if;
	import tsct_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [TRIG_W-1:0]  sine_value;
	logic signed [TRIG_W-1:0]  cosine_value;
	logic signed [TAN_W-1:0]   tangent_value;
	logic                      divide_by_zero;
	modport source (output valid, sine_value, cosine_value, tangent_value, divide_by_zero,
		input ready);
	modport sink   (input valid, sine_value, cosine_value, tangent_value, divide_by_zero,
		output ready);
endinterface

/* sv/taylor_sine_cosine_tangent.sv */
// Series sine, cosine and tangent. Each beat on angle_ch carries one angle in
// radians (signed Q2.13) and yields exactly one beat on result_ch with the sine
// and cosine in signed Q3.16 (saturated), the tangent in signed Q15.16 (rounded,
// saturated) and a flag for a zero cosine, in which case the tangent is pinned
// to the full-scale value of the sine's sign. A new angle may enter every cycle
// while result_ch is not stalled. The pipe is one input stage, three stages per
// Taylor term (multiply, reciprocal estimate, correct and accumulate), a rounding
// stage, one stage per quotient bit of the restoring tangent divider, and the
// output register. The whole pipe holds while a finished result waits and
// result_ch.ready is low.
module taylor_sine_cosine_tangent (
	input  logic        clk,
	input  logic        arst_n,
	tsct_in_if.sink     angle_ch,
	tsct_out_if.source  result_ch
);
	import tsct_pkg::*;

	localparam logic [TAN_W-1:0] TAN_MAX = {1'b0, {(TAN_W-1){1'b1}}};
	localparam logic [TAN_W-1:0] TAN_MIN = {1'b1, {(TAN_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] CLAMP_HI = SUM_W'((1 << (TRIG_W-1)) - 1);
	localparam logic signed [SUM_W-1:0] CLAMP_LO = -SUM_W'(1 << (TRIG_W-1));

	logic                 adv;
	tsct_term_t           term_pipe [0:NUM_TERMS];
	tsct_div_t            div_pipe  [0:NUM_W];
	tsct_term_t           in_s1;
	tsct_div_t            fin_s1;
	tsct_term_t           last;

	logic signed [SUM_W-1:0] ssum_f, sround, cround;
	logic signed [TRIG_W-1:0] sv, cv;
	logic [TRIG_W-1:0]    sm, cm;

	logic                 out_vld_q;
	logic signed [TRIG_W-1:0] sine_q, cosine_q;
	logic signed [TAN_W-1:0]  tan_q;
	logic                 dz_q;
	logic signed [TAN_W-1:0]  tan_nxt;
	logic [NUM_W-1:0]     quo;

	// advance everything unless a finished result is still waiting
	assign adv            = !out_vld_q || result_ch.ready;
	assign angle_ch.ready = adv;

	// round half away from zero to FRACTION_BITS; the caller clamps to the 20-bit range
	function automatic logic signed [SUM_W-1:0] narrow(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] rnd;
		mag = s[SUM_W-1] ? -s : s;
		rnd = (mag + SUM_W'(1 << (GUARD_BITS-1))) >> GUARD_BITS;
		return s[SUM_W-1] ? -$signed(rnd) : $signed(rnd);
	endfunction

	// input stage: split sign and magnitude, seed the series
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1 <= '0;
		end else if (adv) begin
			in_s1.vld  <= angle_ch.valid;
			in_s1.neg  <= angle_ch.angle[ANGLE_W-1];
			in_s1.mag  <= angle_ch.angle[ANGLE_W-1] ? ANGLE_W'(-angle_ch.angle)
			                                        : ANGLE_W'(angle_ch.angle);
			in_s1.term <= TERM_W'(1) << WORK_BITS;
			in_s1.ssum <= '0;
			in_s1.csum <= SUM_W'(1) << WORK_BITS;
		end
	end

	assign term_pipe[0] = in_s1;

	// one three-stage unit per series term, n = 1 .. 2*SERIES_TERMS-1
	for (genvar i = 0; i < NUM_TERMS; i++) begin : g_term
		tsct_term u_term (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.step   (STEP_W'(i + 1)),
			.d      (term_pipe[i]),
			.q      (term_pipe[i+1])
		);
	end

	assign last = term_pipe[NUM_TERMS];

	// rounding stage: apply the angle's sign to the sine, narrow and clamp
	always_comb begin
		ssum_f = last.neg ? -last.ssum : last.ssum;
		sround = narrow(ssum_f);
		cround = narrow(last.csum);
		if (sround > CLAMP_HI)      sv = CLAMP_HI[TRIG_W-1:0];
		else if (sround < CLAMP_LO) sv = CLAMP_LO[TRIG_W-1:0];
		else                        sv = sround[TRIG_W-1:0];
		if (cround > CLAMP_HI)      cv = CLAMP_HI[TRIG_W-1:0];
		else if (cround < CLAMP_LO) cv = CLAMP_LO[TRIG_W-1:0];
		else                        cv = cround[TRIG_W-1:0];
		sm = sv[TRIG_W-1] ? TRIG_W'(-sv) : TRIG_W'(sv);
		cm = cv[TRIG_W-1] ? TRIG_W'(-cv) : TRIG_W'(cv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s1 <= '0;
		end else if (adv) begin
			fin_s1.vld  <= last.vld;
			fin_s1.sv   <= sv;
			fin_s1.cv   <= cv;
			fin_s1.tneg <= sv[TRIG_W-1] != cv[TRIG_W-1];
			fin_s1.dz   <= cv == '0;
			fin_s1.cm   <= cm;
			fin_s1.rem  <= '0;
			// numerator carries half the divisor for round half up
			fin_s1.rq   <= (NUM_W'(sm) << FRACTION_BITS) + NUM_W'(cm >> 1);
		end
	end

	assign div_pipe[0] = fin_s1;

	// restoring divider, one quotient bit per stage
	for (genvar j = 0; j < NUM_W; j++) begin : g_div
		tsct_div_step u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (div_pipe[j]),
			.q      (div_pipe[j+1])
		);
	end

	// sign and saturate the quotient; zero cosine pins full scale
	always_comb begin
		quo = div_pipe[NUM_W].rq;
		if (div_pipe[NUM_W].dz) begin
			tan_nxt = div_pipe[NUM_W].sv[TRIG_W-1] ? TAN_MIN : TAN_MAX;
		end else if (div_pipe[NUM_W].tneg) begin
			tan_nxt = (quo > NUM_W'(TAN_MIN)) ? TAN_MIN : TAN_W'(-quo);
		end else begin
			tan_nxt = (quo > NUM_W'(TAN_MAX)) ? TAN_MAX : TAN_W'(quo);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (adv) out_vld_q <= div_pipe[NUM_W].vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sine_q   <= div_pipe[NUM_W].sv;
			cosine_q <= div_pipe[NUM_W].cv;
			tan_q    <= tan_nxt;
			dz_q     <= div_pipe[NUM_W].dz;
		end
	end

	assign result_ch.valid          = out_vld_q;
	assign result_ch.sine_value     = sine_q;
	assign result_ch.cosine_value   = cosine_q;
	assign result_ch.tangent_value  = tan_q;
	assign result_ch.divide_by_zero = dz_q;

endmodule

/* sv/tsct_term.sv */
module tsct_term (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [tsct_pkg::STEP_W-1:0]  step,
	input  tsct_pkg::tsct_term_t         d,
	output tsct_pkg::tsct_term_t         q
);
	import tsct_pkg::*;

	tsct_term_t           t_s1, t_s2, t_s3;
	logic [U_W-1:0]       u_s1, u_s2;
	logic [U_W-1:0]       q0_s2;
	logic [PROD_W:0]      prod;
	logic [U_W+RECIP_W-1:0] scaled;
	logic [U_W+STEP_W-1:0] qn;
	logic [U_W+STEP_W-1:0] r;
	logic [U_W-1:0]       qf;
	logic [STEP_W-1:0]    half;
	tsct_term_t           nxt;

	// multiply by the angle and add half the divisor
	assign prod = (PROD_W+1)'(d.term) * (PROD_W+1)'(d.mag)
		+ ((PROD_W+1)'(step) << (ANGLE_FRAC - 1));

	// quotient estimate by reciprocal, never above the true value
	assign scaled = (U_W+RECIP_W)'(u_s1) * (U_W+RECIP_W)'(recip(step));

	assign qn   = (U_W+STEP_W)'(q0_s2) * (U_W+STEP_W)'(step);
	assign r    = (U_W+STEP_W)'(u_s2) - qn;
	assign qf   = (r >= (U_W+STEP_W)'(step)) ? q0_s2 + U_W'(1) : q0_s2;
	assign half = step >> 1;

	always_comb begin
		nxt      = t_s2;
		nxt.term = qf[TERM_W-1:0];
		if (step[0]) begin
			if (half[0]) nxt.ssum = t_s2.ssum - SUM_W'(qf[TERM_W-1:0]);
			else         nxt.ssum = t_s2.ssum + SUM_W'(qf[TERM_W-1:0]);
		end else begin
			if (half[0]) nxt.csum = t_s2.csum - SUM_W'(qf[TERM_W-1:0]);
			else         nxt.csum = t_s2.csum + SUM_W'(qf[TERM_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_s1 <= '0;
			t_s2 <= '0;
			t_s3 <= '0;
		end else if (en) begin
			t_s1 <= d;
			t_s2 <= t_s1;
			t_s3 <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= U_W'(prod >> ANGLE_FRAC);
			u_s2  <= u_s1;
			q0_s2 <= scaled[U_W+U_W-1:U_W];
		end
	end

	assign q = t_s3;

endmodule

/* sv/tsct_div_step.sv */
module tsct_div_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  tsct_pkg::tsct_div_t d,
	output tsct_pkg::tsct_div_t q
);
	import tsct_pkg::*;

	tsct_div_t         nxt;
	tsct_div_t         q_s1;
	logic [REM_W-1:0]  t;
	logic              fit;

	// shift in one numerator bit, subtract the divisor when it fits
	assign t   = {d.rem[REM_W-2:0], d.rq[NUM_W-1]};
	assign fit = t >= REM_W'(d.cm);

	always_comb begin
		nxt     = d;
		nxt.rem = fit ? t - REM_W'(d.cm) : t;
		nxt.rq  = {d.rq[NUM_W-2:0], fit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) q_s1 <= '0;
		else if (en) q_s1 <= nxt;
	end

	assign q = q_s1;

endmodule
